FILE: hdl/bbfe_pkg.sv
// Package for the byte-budget FIFO evictor.
// Holds sizes, the stored entry type, cell control and transaction payload structs.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps

package bbfe_pkg;

    localparam int DEPTH       = 64;
    localparam int HANDLE_BITS = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int BYTE_W      = 16;
    localparam logic [BYTE_W-1:0] BUDGET_RESET = 16'd4096;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [BYTE_W-1:0]      size;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    typedef struct packed {
        logic [15:0] blob_handle;
        logic [15:0] blob_bytes;
    } blob_t;

    typedef struct packed {
        logic        evicted_valid;
        logic [15:0] evicted_handle;
        logic [15:0] evicted_size;
        logic        new_tracked;
        logic [6:0]  live_count;
        logic [15:0] live_bytes;
        logic        last;
    } result_t;

endpackage

FILE: hdl/bbfe_cell.sv
// One age-queue cell: holds one entry, loads a new one or takes its younger neighbor's.
// Depends on bbfe_pkg.
`timescale 1ns / 1ps

module bbfe_cell
    import bbfe_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  entry_t    up,
    input  entry_t    fresh,
    output entry_t    q
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load)
        begin
            entry_next = fresh;
        end
        else if (ctl.shift)
        begin
            entry_next = up;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

FILE: hdl/bbfe_chain.sv
// Row of DEPTH cells, oldest entry at cell 0; shifting moves every entry one cell older.
// Depends on bbfe_pkg and bbfe_cell.
`timescale 1ns / 1ps

module bbfe_chain
    import bbfe_pkg::*;
(
    input  logic             clk,
    input  logic             shift,
    input  logic             load,
    input  logic [CNT_W-1:0] wr_pos,
    input  entry_t           fresh,
    output entry_t           head
);

    entry_t q [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            cell_ctl_t ctl;
            entry_t    up;

            assign ctl.shift = shift;
            assign ctl.load  = load && (wr_pos == CNT_W'(i));

            if (i == DEPTH - 1)
            begin : g_top
                assign up = '0;
            end
            else
            begin : g_mid
                assign up = q[i+1];
            end

            bbfe_cell u_cell (
                .clk   (clk),
                .ctl   (ctl),
                .up    (up),
                .fresh (fresh),
                .q     (q[i])
            );
        end
    endgenerate

    assign head = q[0];

endmodule

FILE: hdl/byte_budget_fifo_evictor.sv
// Top level of the byte-budget FIFO evictor: sequencer, totals, output register.
// Depends on bbfe_pkg and bbfe_chain.
//
//   channel   direction  handshake                  payload
//   blob      in         blob_valid / blob_stall    blob_t   (handle, length)
//   result    out        result_valid / result_stall result_t
//   cfg       in         cfg_we                     cfg_data (byte budget)
//
// An item is accepted, then entries are evicted through cell 0 of the chain one by one,
// the last eviction also appending the new blob; with nothing to evict it is appended alone if a cell is free.
// A stalled output register holds the sequencer between steps.
// blob_stall stays high from acceptance until the final result is in the output register.
// Reset clears the count, byte total and sequencer; the budget returns to 4096.
`timescale 1ns / 1ps

module byte_budget_fifo_evictor
    import bbfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              blob_valid,
    output logic              blob_stall,
    input  blob_t             blob,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,
    input  logic              cfg_we,
    input  logic [BYTE_W-1:0] cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] total_reg, total_next;
    logic [BYTE_W-1:0] budget_reg;
    entry_t            item_reg;
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              accept;
    logic              out_free;
    logic              step;
    logic              need_evict;
    logic              more;
    logic [BYTE_W:0]   sum_now;
    logic [BYTE_W-1:0] total_ev;
    logic [BYTE_W:0]   sum_ev;
    logic              shift;
    logic              load;
    logic [CNT_W-1:0]  wr_pos;
    entry_t            head;

    assign blob_stall = (state_reg != ST_IDLE);
    assign accept     = blob_valid && !blob_stall;
    assign out_free   = !out_valid_reg || !result_stall;
    assign step       = (state_reg == ST_RUN) && out_free;

    assign sum_now    = {1'b0, total_reg} + {1'b0, item_reg.size};
    assign need_evict = (count_reg != '0) && (sum_now > {1'b0, budget_reg});
    assign total_ev   = total_reg - head.size;
    assign sum_ev     = {1'b0, total_ev} + {1'b0, item_reg.size};
    assign more       = (count_reg > CNT_W'(1)) && (sum_ev > {1'b0, budget_reg});

    assign shift  = step && need_evict;
    assign load   = step && ((need_evict && !more) ||
                             (!need_evict && (count_reg < CNT_W'(DEPTH))));
    assign wr_pos = need_evict ? (count_reg - CNT_W'(1)) : count_reg;

    bbfe_chain u_chain (
        .clk    (clk),
        .shift  (shift),
        .load   (load),
        .wr_pos (wr_pos),
        .fresh  (item_reg),
        .head   (head)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        if (accept)
        begin
            state_next = ST_RUN;
        end

        if (step)
        begin
            out_valid_next = 1'b1;
            if (need_evict)
            begin
                out_next.evicted_valid  = 1'b1;
                out_next.evicted_handle = 16'(head.handle);
                out_next.evicted_size   = head.size;
                if (more)
                begin
                    // evict only, keep walking
                    count_next = count_reg - CNT_W'(1);
                    total_next = total_ev;
                    out_next.new_tracked = 1'b0;
                    out_next.last        = 1'b0;
                end
                else
                begin
                    // evict and append in the same step: count holds
                    total_next = sum_ev[BYTE_W-1:0];
                    out_next.new_tracked = 1'b1;
                    out_next.last        = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            else
            begin
                out_next.evicted_valid  = 1'b0;
                out_next.evicted_handle = '0;
                out_next.evicted_size   = '0;
                out_next.last           = 1'b1;
                out_next.new_tracked    = load;
                state_next              = ST_IDLE;
                if (load)
                begin
                    count_next = count_reg + CNT_W'(1);
                    total_next = sum_now[BYTE_W-1:0];
                end
            end
            out_next.live_count = 7'(count_next);
            out_next.live_bytes = total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            budget_reg    <= BUDGET_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                budget_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (accept)
        begin
            item_reg.handle <= HANDLE_BITS'(blob.blob_handle);
            item_reg.size   <= blob.blob_bytes;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: hdl/bbfe_checker.sv
// Port-level checker for the byte-budget FIFO evictor, bound to the top level.
// Depends on bbfe_pkg and byte_budget_fifo_evictor.
`timescale 1ns / 1ps

module bbfe_checker
    import bbfe_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              blob_valid,
    input logic              blob_stall,
    input logic              result_valid,
    input logic              result_stall,
    input result_t           result
);

    // hold a stalled result transaction
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // stall the input once a transaction is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        blob_valid && !blob_stall |=> blob_stall)
        else $error("second blob taken while busy");

    a_mid_evict: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> result.evicted_valid && !result.new_tracked)
        else $error("non-final result without eviction");

    a_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last && result.new_tracked |-> result.live_count != 7'd0)
        else $error("tracked blob but empty list");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.live_count <= 7'(DEPTH))
        else $error("live count beyond depth");

endmodule

bind byte_budget_fifo_evictor bbfe_checker u_bbfe_checker (.*);
